// ===== src/bbr_pkg.sv =====
// ----------------------------------------------------------------------------
// bbr_pkg: shared types and constants for the 3x3 RGB box blur
// Pixel, window-sum and line-store types, plus the reciprocal table used by
// the rounding divider.
// ----------------------------------------------------------------------------
package bbr_pkg;

  localparam int MaxWidth  = 1024;
  localparam int FwW       = 11;   // frame_width register
  localparam int ChanW     = 8;
  localparam int SumW      = 12;   // 9 * 255 fits
  localparam int CntW      = 4;    // neighbour count 1..9
  localparam int NumW      = SumW + 2;  // 2*sum + count
  localparam int RecipW    = 16;
  localparam int RecipSh   = 16;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pixel_t;

  typedef struct packed {
    pixel_t older;
    pixel_t newer;
  } line_pair_t;

  typedef struct packed {
    logic [SumW-1:0] red;
    logic [SumW-1:0] green;
    logic [SumW-1:0] blue;
    logic [CntW-1:0] cnt;
  } sum_t;

  // which neighbours take part in one result
  typedef struct packed {
    logic centre_right;  // centre is the newest window column
    logic left_ok;
    logic right_ok;
    logic rows_full;     // top row of the window is in the frame
  } emit_t;

  // floor(2^16 / (2*cnt)); within one of the true quotient for our range
  function automatic logic [RecipW-1:0] recip(input logic [CntW-1:0] cnt);
    logic [RecipW-1:0] r;
    case (cnt)
      4'd1:    r = 16'd32768;
      4'd2:    r = 16'd16384;
      4'd3:    r = 16'd10922;
      4'd4:    r = 16'd8192;
      4'd5:    r = 16'd6553;
      4'd6:    r = 16'd5461;
      4'd7:    r = 16'd4681;
      4'd8:    r = 16'd4096;
      4'd9:    r = 16'd3640;
      default: r = 16'd32768;
    endcase
    return r;
  endfunction

endpackage

// ===== src/bbr_line_mem.sv =====
// ----------------------------------------------------------------------------
// bbr_line_mem: line store for the two previous rows
// One entry per column holds the older and the newer row side by side.
// Synchronous, one read and one write port, read data registered.
// ----------------------------------------------------------------------------
module bbr_line_mem #(
  parameter int Depth = bbr_pkg::MaxWidth,
  parameter int AddrW = 10
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output bbr_pkg::line_pair_t rd_data_o,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  bbr_pkg::line_pair_t wr_data_i
);

  bbr_pkg::line_pair_t mem [Depth];
  bbr_pkg::line_pair_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/bbr_window.sv =====
// ----------------------------------------------------------------------------
// bbr_window: 3x3 window registers and neighbourhood sums
// Shifts in one column per item and adds up the in-frame cells around the
// selected centre, per channel, with their count.
// ----------------------------------------------------------------------------
module bbr_window (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  bbr_pkg::pixel_t top_i,
  input  bbr_pkg::pixel_t mid_i,
  input  bbr_pkg::pixel_t bot_i,
  input  logic            bot_real_i,
  input  bbr_pkg::emit_t  emit_i,
  output bbr_pkg::sum_t   sum_o
);

  // win_q[row][col], row 0 top, col 2 newest
  bbr_pkg::pixel_t win_q [3][3];
  logic [2:0]      bv_q;   // bit (2-col): bottom cell came from a pixel item

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[r][j] <= '0;
        end
      end
      bv_q <= '0;
    end else if (shift_i) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= top_i;
      win_q[1][2] <= mid_i;
      win_q[2][2] <= bot_i;
      bv_q        <= {bv_q[1:0], bot_real_i};
    end
  end

  logic [2:0] col_en;
  logic [8:0] cell_en;

  always_comb begin
    if (emit_i.centre_right) begin
      col_en = {1'b1, emit_i.left_ok, 1'b0};
    end else begin
      col_en = {emit_i.right_ok, 1'b1, emit_i.left_ok};
    end
    for (int j = 0; j < 3; j++) begin
      cell_en[j]     = col_en[j] & emit_i.rows_full;
      cell_en[3 + j] = col_en[j];
      cell_en[6 + j] = col_en[j] & bv_q[2 - j];
    end
  end

  always_comb begin
    sum_o = '0;
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        if (cell_en[r*3 + j]) begin
          sum_o.red   = sum_o.red   + bbr_pkg::SumW'(win_q[r][j].red);
          sum_o.green = sum_o.green + bbr_pkg::SumW'(win_q[r][j].green);
          sum_o.blue  = sum_o.blue  + bbr_pkg::SumW'(win_q[r][j].blue);
        end
      end
    end
    sum_o.cnt = bbr_pkg::CntW'($countones(cell_en));
  end

endmodule

// ===== src/bbr_div.sv =====
// ----------------------------------------------------------------------------
// bbr_div: rounded mean per channel
// Computes (2*sum + cnt) / (2*cnt) in two registered stages: reciprocal
// multiply, then a single remainder check to correct the estimate.
// ----------------------------------------------------------------------------
module bbr_div (
  input  logic            clk_i,
  input  bbr_pkg::sum_t   sum_i,
  output bbr_pkg::pixel_t mean_o
);

  localparam int NumW  = bbr_pkg::NumW;
  localparam int ProdW = NumW + bbr_pkg::RecipW;
  localparam int DW    = bbr_pkg::CntW + 1;
  localparam int ChanW = bbr_pkg::ChanW;

  logic [NumW-1:0]  num   [3];
  logic [ProdW-1:0] prod  [3];
  logic [NumW-1:0]  num_q [3];
  logic [ChanW-1:0] q0_q  [3];
  logic [DW-1:0]    d_q;
  logic [ChanW-1:0] q_d   [3];
  logic [NumW-1:0]  rem   [3];
  bbr_pkg::pixel_t  mean_q;

  always_comb begin
    num[0] = {1'b0, sum_i.red,   1'b0} + NumW'(sum_i.cnt);
    num[1] = {1'b0, sum_i.green, 1'b0} + NumW'(sum_i.cnt);
    num[2] = {1'b0, sum_i.blue,  1'b0} + NumW'(sum_i.cnt);
    for (int i = 0; i < 3; i++) begin
      prod[i] = ProdW'(num[i]) * ProdW'(bbr_pkg::recip(sum_i.cnt));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      num_q[i] <= num[i];
      q0_q[i]  <= prod[i][bbr_pkg::RecipSh +: ChanW];
    end
    d_q <= {sum_i.cnt, 1'b0};
  end

  // estimate is exact or one short
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem[i] = num_q[i] - NumW'(q0_q[i]) * NumW'(d_q);
      q_d[i] = (rem[i] >= NumW'(d_q)) ? q0_q[i] + ChanW'(1) : q0_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q.red   <= q_d[0];
    mean_q.green <= q_d[1];
    mean_q.blue  <= q_d[2];
  end

  assign mean_o = mean_q;

endmodule

// ===== src/box_blur_3x3_rgb.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb: streaming 3x3 box blur on 24-bit RGB pixels
// Line store plus 3x3 window; each result is the rounded mean of the
// in-frame neighbours per channel. Flush items release the last row.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                  handshake
//  s_axis   in   tdata red/green/blue, tuser flush flag   tvalid/tready
//  m_axis   out  tdata red/green/blue, tlast last result  tvalid/tready
//  cfg      in   frame_width (11 bits)                    cfg_valid/cfg_ready
//
//  An item passes ST_IDLE and ST_WIN, then ST_SUM, ST_DV1, ST_DV2 and ST_OUT
//  once for each of its n = 0, 1 or 2 results; ST_OUT waits on m_axis_tready.
//  The line store read-modify-write and the two-stage rounding divider serve
//  one item at a time. Reset clears counters, window and output valid;
//  the line store has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = bbr_pkg::MaxWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // in_red[7:0], in_green[15:8], in_blue[23:16]
  input  logic        s_axis_tuser,   // func: 0 pixel, 1 flush
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_red[7:0], out_green[15:8], out_blue[23:16]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i
);

  localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW   = (ColW + 1 > bbr_pkg::FwW) ? ColW + 1 : bbr_pkg::FwW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WIN  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_DV1  = 3'd3;
  localparam logic [2:0] ST_DV2  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [bbr_pkg::FwW-1:0] fw_q;
  logic [ColW-1:0]        col_q, col_d;
  logic [1:0]             rows_q, rows_d;
  logic [ColW-1:0]        c_q;
  bbr_pkg::pixel_t        px_q;
  logic                   flush_q;
  bbr_pkg::emit_t         emit_q, emit_d;
  logic                   last_q, last_d;
  logic                   second_pend_q, second_pend_d;
  bbr_pkg::sum_t          sum_q;
  bbr_pkg::sum_t          win_sum;
  bbr_pkg::pixel_t        mean;
  logic                   m_valid_q;
  bbr_pkg::pixel_t        m_data_q;
  logic                   m_last_q;

  logic [WW-1:0]          w_eff;
  logic [WW-1:0]          fw_ext;
  logic [ColW-1:0]        c_eff;
  logic                   at_end;
  logic                   s_acc;
  logic                   out_load;
  bbr_pkg::line_pair_t    rd_data;
  bbr_pkg::line_pair_t    wr_data;
  bbr_pkg::pixel_t        in_px;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // width zero acts as one, anything above the store depth saturates
  assign fw_ext = WW'(fw_q);
  always_comb begin
    if (fw_q == '0) begin
      w_eff = WW'(1);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
  end

  assign c_eff  = (WW'(col_q) >= w_eff) ? '0 : col_q;
  assign at_end = (WW'(c_q) + WW'(1)) >= w_eff;

  assign in_px.red   = s_axis_tdata[7:0];
  assign in_px.green = s_axis_tdata[15:8];
  assign in_px.blue  = s_axis_tdata[23:16];

  assign wr_data.older = rd_data.newer;
  assign wr_data.newer = px_q;

  bbr_line_mem #(
    .Depth (MAX_WIDTH),
    .AddrW (ColW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (s_acc),
    .rd_addr_i (c_eff),
    .rd_data_o (rd_data),
    .wr_en_i   (state_q == ST_WIN),
    .wr_addr_i (c_q),
    .wr_data_i (wr_data)
  );

  bbr_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_i    (state_q == ST_WIN),
    .top_i      (rd_data.older),
    .mid_i      (rd_data.newer),
    .bot_i      (px_q),
    .bot_real_i (~flush_q),
    .emit_i     (emit_q),
    .sum_o      (win_sum)
  );

  bbr_div u_div (
    .clk_i  (clk_i),
    .sum_i  (sum_q),
    .mean_o (mean)
  );

  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d       = state_q;
    col_d         = col_q;
    rows_d        = rows_q;
    emit_d        = emit_q;
    last_d        = last_q;
    second_pend_d = second_pend_q;
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          state_d = ST_WIN;
        end
      end
      ST_WIN: begin
        emit_d.rows_full = (rows_q == 2'd2);
        if (rows_q != 2'd0 && c_q != '0) begin
          emit_d.centre_right = 1'b0;
          emit_d.left_ok      = (c_q > ColW'(1));
          emit_d.right_ok     = 1'b1;
          last_d              = ~at_end;
          second_pend_d       = at_end;
          state_d             = ST_SUM;
        end else if (rows_q != 2'd0 && at_end) begin
          emit_d.centre_right = 1'b1;
          emit_d.left_ok      = (c_q != '0);
          emit_d.right_ok     = 1'b0;
          last_d              = 1'b1;
          second_pend_d       = 1'b0;
          state_d             = ST_SUM;
        end else begin
          state_d = ST_IDLE;
        end
        if (at_end) begin
          col_d = '0;
          if (flush_q) begin
            rows_d = 2'd0;
          end else if (rows_q != 2'd2) begin
            rows_d = rows_q + 2'd1;
          end
        end else begin
          col_d = c_q + ColW'(1);
        end
      end
      ST_SUM: state_d = ST_DV1;
      ST_DV1: state_d = ST_DV2;
      ST_DV2: state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          if (second_pend_q) begin
            emit_d.centre_right = 1'b1;
            emit_d.left_ok      = (c_q != '0);
            emit_d.right_ok     = 1'b0;
            last_d              = 1'b1;
            second_pend_d       = 1'b0;
            state_d             = ST_SUM;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // a new width starts a new frame
    if (cfg_valid_i) begin
      col_d  = '0;
      rows_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      fw_q          <= bbr_pkg::FwW'(bbr_pkg::MaxWidth);
      col_q         <= '0;
      rows_q        <= 2'd0;
      emit_q        <= '0;
      last_q        <= 1'b0;
      second_pend_q <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      col_q         <= col_d;
      rows_q        <= rows_d;
      emit_q        <= emit_d;
      last_q        <= last_d;
      second_pend_q <= second_pend_d;
      if (cfg_valid_i) begin
        fw_q <= cfg_data_i;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      c_q     <= c_eff;
      flush_q <= s_axis_tuser;
      px_q    <= s_axis_tuser ? '0 : in_px;
    end
    if (state_q == ST_SUM) begin
      sum_q <= win_sum;
    end
    if (out_load) begin
      m_data_q <= mean;
      m_last_q <= last_q;
    end
  end

  assign m_axis_tvalid       = m_valid_q;
  assign m_axis_tdata[7:0]   = m_data_q.red;
  assign m_axis_tdata[15:8]  = m_data_q.green;
  assign m_axis_tdata[23:16] = m_data_q.blue;
  assign m_axis_tlast        = m_last_q;

`ifndef SYNTHESIS
  // line store read-modify-write: no item may follow in the very next cycle
  a_rmw_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_acc)
    else $error("input accepted during line store update");

  a_no_stale_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !second_pend_q)
    else $error("second result pending while idle");

  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DV1) |-> (sum_q.cnt != '0) && (sum_q.cnt <= bbr_pkg::CntW'(9)))
    else $error("neighbour count out of range");

  a_out_only_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("result shown without divider pass");
`endif

endmodule

// ===== sim/tb_box_blur_3x3_rgb.sv =====
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_rgb: self-checking bench for the 3x3 RGB box blur
// Raster frames go in over s_axis with random gaps. A local line store and
// window model predicts each blurred pixel, and the model is checked against
// m_axis under random back-pressure. The frame width is stepped through
// small, odd and extreme values, including zero and saturating writes.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_rgb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            flush;
    bbr_pkg::pixel_t px;
  } stream_item_t;

  typedef struct {
    logic [bbr_pkg::ChanW-1:0] red;
    logic [bbr_pkg::ChanW-1:0] green;
    logic [bbr_pkg::ChanW-1:0] blue;
    logic                      last;
  } blurred_px_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [10:0] cfg_data_i = '0;

  box_blur_3x3_rgb u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Blur predictor: line stores, window and counters of its own
  // ---------------------------------------------------------------------------
  bbr_pkg::pixel_t         ls_older [bbr_pkg::MaxWidth];
  bbr_pkg::pixel_t         ls_newer [bbr_pkg::MaxWidth];
  bbr_pkg::pixel_t         win [9];  // row*3 + col, row 0 on top, col 2 newest
  logic [2:0]              bottom_real;  // bit (2-col): bottom cell from a pixel item
  int unsigned             col_next;
  int unsigned             rows_done;
  logic [bbr_pkg::FwW-1:0] width_cfg;

  blurred_px_t     blurred_q [$];
  stream_item_t    pixel_q [$];
  int unsigned     items_pushed;
  int unsigned     items_taken;
  int unsigned     mismatches;

  function automatic void blur_reset();
    for (int i = 0; i < bbr_pkg::MaxWidth; i++) begin
      ls_older[i] = '0;
      ls_newer[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    bottom_real = '0;
    col_next    = 0;
    rows_done   = 0;
    width_cfg   = bbr_pkg::FwW'(bbr_pkg::MaxWidth);
  endfunction

  function automatic void blur_set_width(logic [bbr_pkg::FwW-1:0] w);
    width_cfg = w;
    col_next  = 0;
    rows_done = 0;
  endfunction

  // rounded mean over the neighbours of window column 'centre' that exist
  function automatic blurred_px_t box_mean(int centre, bit left_ok, bit right_ok,
                                           bit last);
    int unsigned sr, sg, sb, cnt;
    blurred_px_t m;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int j = 0; j < 3; j++) begin
      if (j + 1 < centre || j > centre + 1) continue;
      if (j + 1 == centre && !left_ok) continue;
      if (j == centre + 1 && !right_ok) continue;
      for (int r = 0; r < 3; r++) begin
        if (r == 0 && rows_done < 2) continue;
        if (r == 2 && !bottom_real[2-j]) continue;
        sr += win[r*3+j].red;
        sg += win[r*3+j].green;
        sb += win[r*3+j].blue;
        cnt++;
      end
    end
    m.red   = bbr_pkg::ChanW'((2*sr + cnt) / (2*cnt));
    m.green = bbr_pkg::ChanW'((2*sg + cnt) / (2*cnt));
    m.blue  = bbr_pkg::ChanW'((2*sb + cnt) / (2*cnt));
    m.last  = last;
    return m;
  endfunction

  function automatic void blur_step(stream_item_t it);
    int unsigned w, c;
    bbr_pkg::pixel_t px, top, mid;
    bit at_end;
    w = (width_cfg == 0) ? 1 : ((width_cfg > bbr_pkg::MaxWidth) ? bbr_pkg::MaxWidth
                                                                : width_cfg);
    c = (col_next >= w) ? 0 : col_next;
    px  = it.flush ? '0 : it.px;
    top = ls_older[c];
    mid = ls_newer[c];
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    bottom_real = {bottom_real[1:0], ~it.flush};
    ls_older[c] = mid;
    ls_newer[c] = px;
    at_end = (c + 1 >= w);
    if (rows_done >= 1) begin
      if (c >= 1) blurred_q.push_back(box_mean(1, c >= 2, 1'b1, !at_end));
      if (at_end) blurred_q.push_back(box_mean(2, c >= 1, 1'b0, 1'b1));
    end
    if (at_end) begin
      col_next = 0;
      if (it.flush) rows_done = 0;
      else if (rows_done < 2) rows_done++;
    end else begin
      col_next = c + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, limit
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    blur_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Idling control
  // ---------------------------------------------------------------------------
  logic calm = 1'b0;     // no gaps on either side while set
  logic rx_hold = 1'b0;  // long receiver hold-off
  logic hold_go = 1'b0;  // stimulus has queued the frame for the hold-off

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // hold the result side off long enough for the block to back up its input
  initial begin
    wait (hold_go);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------
  stream_item_t cur_item;
  int           tx_gap = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        blur_step(cur_item);
        items_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          cur_item = pixel_q.pop_front();
          s_axis_tdata  <= cur_item.px;
          s_axis_tuser  <= cur_item.flush;
          s_axis_tvalid <= 1'b1;
          tx_gap = calm ? 0 : pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and checker
  // ---------------------------------------------------------------------------
  blurred_px_t want;
  int          rx_gap = 0;

  task automatic note_mismatch(string what, int got, int wanted);
    if (mismatches < 50)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, wanted);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (blurred_q.size() == 0) begin
          note_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = blurred_q.pop_front();
          if (m_axis_tdata[7:0] !== want.red)
            note_mismatch("red", m_axis_tdata[7:0], want.red);
          if (m_axis_tdata[15:8] !== want.green)
            note_mismatch("green", m_axis_tdata[15:8], want.green);
          if (m_axis_tdata[23:16] !== want.blue)
            note_mismatch("blue", m_axis_tdata[23:16], want.blue);
          if (m_axis_tlast !== want.last)
            note_mismatch("tlast", m_axis_tlast, want.last);
        end
      end
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_gap = calm ? 0 : pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_px(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    stream_item_t it;
    it.flush    = 1'b0;
    it.px.red   = r;
    it.px.green = g;
    it.px.blue  = b;
    pixel_q.push_back(it);
    items_pushed++;
  endtask

  // flush payload is don't-care, so fill it with noise
  task automatic push_flush();
    stream_item_t it;
    it.flush = 1'b1;
    it.px    = bbr_pkg::pixel_t'(24'($urandom));
    pixel_q.push_back(it);
    items_pushed++;
  endtask

  task automatic push_rand_px();
    logic [7:0] ch [3];
    for (int i = 0; i < 3; i++)
      ch[i] = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                          : 8'($urandom_range(0, 255));
    push_px(ch[0], ch[1], ch[2]);
  endtask

  // everything sent has been taken and every result has come out
  task automatic wait_drained();
    while (items_pushed != items_taken || blurred_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_width(logic [bbr_pkg::FwW-1:0] w);
    wait_drained();
    cfg_data_i  <= w;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    blur_set_width(w);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_rand_frame(int w, output int n);
    int rows;
    n = 0;
    rows = $urandom_range(0, 5);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < w; c++) begin
        // a broken frame stops part-way through a row
        if ($urandom_range(0, 199) == 0) return;
        if ($urandom_range(0, 11) == 0) push_flush();
        else push_rand_px();
        n++;
      end
    end
    if ($urandom_range(0, 7) == 0) return;
    for (int c = 0; c < w; c++) begin
      if (c != w - 1 && $urandom_range(0, 15) == 0) push_rand_px();
      else push_flush();
      n++;
    end
  endtask

  initial begin
    int rand_items, n, w, pick;
    rand_items = 0;
    wait (rst_ni);
    @(posedge clk_i);

    // width 3: extremes, a flush inside a row, then a flush row to end the frame
    write_width(11'd3);
    push_px(8'h00, 8'h00, 8'h00); push_px(8'hFF, 8'hFF, 8'hFF); push_px(8'h55, 8'hAA, 8'h0F);
    push_px(8'hF0, 8'h33, 8'hCC); push_flush();                 push_px(8'hFF, 8'h00, 8'hFF);
    push_px(8'h01, 8'h02, 8'h03); push_px(8'hFE, 8'hFD, 8'hFC); push_px(8'h80, 8'h7F, 8'h81);
    push_flush(); push_flush(); push_flush();
    // single column
    write_width(11'd1);
    push_px(8'hFF, 8'hFF, 8'hFF); push_px(8'h00, 8'h00, 8'h00); push_px(8'h0A, 8'h14, 8'h1E);
    push_flush();
    // zero width behaves as one column; leading flush ends a frame at once
    write_width(11'd0);
    push_flush(); push_px(8'hC8, 8'h64, 8'h32); push_flush();
    // flush in the first row, stored as black
    write_width(11'd2);
    push_flush(); push_px(8'h4D, 8'h58, 8'h63);
    push_px(8'h01, 8'h01, 8'h01); push_px(8'h02, 8'h02, 8'h02);
    push_flush(); push_flush();

    // a whole frame queued while the result side is held off
    write_width(11'd8);
    hold_go <= 1'b1;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 8; c++) push_rand_px();
    for (int c = 0; c < 8; c++) push_flush();

    // random frames, mostly narrow
    while (rand_items < 80) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) w = 1;
      else if (pick < 20) w = 2;
      else if (pick < 75) w = $urandom_range(3, 12);
      else if (pick < 92) w = $urandom_range(13, 40);
      else w = $urandom_range(41, 100);
      write_width(bbr_pkg::FwW'(w));
      calm <= ($urandom_range(0, 3) == 0);
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        if ($urandom_range(0, 3) == 0) wait_drained();
        push_rand_frame(w, n);
        rand_items += n;
      end
    end
    calm <= 1'b0;

    // oversized width saturates to the widest frame; the wrap into the
    // second row shows it
    write_width(11'h7FF);
    for (int c = 0; c < bbr_pkg::MaxWidth + 4; c++) push_rand_px();

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && blurred_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
